FILE: design/assert_macros.svh
// assertion macros for the lru page replacement design files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lrupr_pkg.sv
// shared constants and types for the lru page replacement unit
// no dependencies; used by the frame ram, the scan unit and the top level
package lrupr_pkg;

   // default number of built frames
   localparam int DEF_MAX_FRAMES = 64;

   // fixed field widths
   localparam int ACTIVE_W = 7;
   localparam int PAGE_W   = 31;
   localparam int USED_W   = 6;
   localparam int COUNT_W  = 32;

   // frame count after reset
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd4;

   // control from the sequencer into the scan unit
   typedef struct packed {
      logic start;
      logic sample;
   } scan_ctrl_type;

   // status flags from the scan unit
   typedef struct packed {
      logic hit;
      logic have_empty;
   } scan_flags_type;

endpackage

FILE: design/lru_page_replacement_unit.sv
// lru page replacement unit, fully associative, n = active frame count (1..MAX_FRAMES)
// one item at a time: a new item is taken only once the last result is loaded;
// each item takes two passes over the frame ram, which has one read port
// a search pass reads every active frame, an update pass rewrites every rank
// reset: synchronous; a clearing pass over all MAX_FRAMES entries empties the frame ram
// before the first item is taken; configuration writes are taken at all times
module lru_page_replacement_unit #(
   parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lrupr_pkg::PAGE_W-1:0]        req_page_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_page_fault,
   output logic [lrupr_pkg::USED_W-1:0]        rsp_frame_used,
   output logic [lrupr_pkg::COUNT_W-1:0]       rsp_fault_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrupr_pkg::ACTIVE_W-1:0]      csr_active_frames
);

`include "assert_macros.svh"

   localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W  = (CNT_W > lrupr_pkg::ACTIVE_W) ? CNT_W : lrupr_pkg::ACTIVE_W;
   localparam int PAGE_W = lrupr_pkg::PAGE_W;
   localparam int WORD_W = 1 + RANK_W + PAGE_W;
   localparam int USED_W = lrupr_pkg::USED_W;
   localparam int COUNT_W = lrupr_pkg::COUNT_W;

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);
   localparam logic [CNT_W-1:0]  LAST_IDX = CNT_W'(MAX_FRAMES - 1);

   // sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               addr_ff, addr_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]               rd_idx_ff, rd_idx_in;
   logic [PAGE_W-1:0]              page_ff, page_in;
   logic [CNT_W-1:0]               n_ff, n_in;
   logic [lrupr_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [COUNT_W-1:0]             count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_fault_ff;
   logic [USED_W-1:0]              rsp_used_ff;
   logic [COUNT_W-1:0]             rsp_count_ff;

   logic                 accept, issue, pass_done, rsp_free, rsp_load;
   logic [CMP_W-1:0]     active_ext, n_clamp;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0]    ram_wdata, ram_rdata;
   logic                 ent_valid;
   logic [RANK_W-1:0]    ent_rank, ent_aged;
   logic [PAGE_W-1:0]    ent_page;
   logic [WORD_W-1:0]    new_word;
   logic [IDX_W-1:0]     tgt_idx;
   logic [RANK_W-1:0]    tgt_rank;
   logic                 fill;
   logic                 fault;
   logic [COUNT_W-1:0]   count_next;
   logic [USED_W+IDX_W-1:0] used_wide;

   lrupr_pkg::scan_ctrl_type  scan_ctrl;
   lrupr_pkg::scan_flags_type scan_flags;
   logic [IDX_W-1:0]          hit_idx, empty_idx, victim_idx;
   logic [RANK_W-1:0]         hit_rank, victim_rank;

   // handshakes
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_DONE) && rsp_free;

   // frame count clamped to 1..MAX_FRAMES
   always_comb begin
      active_ext = CMP_W'(active_ff);
      if (active_ext == '0) begin
         n_clamp = CMP_W'(1);
      end else if (active_ext > CMP_W'(MAX_FRAMES)) begin
         n_clamp = CMP_W'(MAX_FRAMES);
      end else begin
         n_clamp = active_ext;
      end
   end

   // read issue and pass completion
   assign issue     = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) && (addr_ff < n_ff);
   assign pass_done = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) && !issue
                      && !rd_valid_ff;
   assign ram_raddr = issue ? addr_ff[IDX_W-1:0] : '0;

   // fields of the word coming back from the ram
   assign ent_valid = ram_rdata[WORD_W-1];
   assign ent_rank  = ram_rdata[PAGE_W +: RANK_W];
   assign ent_page  = ram_rdata[PAGE_W-1:0];
   assign ent_aged  = (ent_rank < RANK_MAX) ? ent_rank + RANK_W'(1) : ent_rank;

   // outcome of the search pass
   assign fault    = !scan_flags.hit;
   assign fill     = !scan_flags.hit && scan_flags.have_empty;
   assign tgt_idx  = scan_flags.hit ? hit_idx : (fill ? empty_idx : victim_idx);
   assign tgt_rank = scan_flags.hit ? hit_rank : victim_rank;

   // rank update for one frame
   always_comb begin
      new_word = ram_rdata;
      if (rd_idx_ff == tgt_idx) begin
         new_word = {1'b1, {RANK_W{1'b0}}, page_ff};
      end else if (ent_valid && (fill || ent_rank < tgt_rank)) begin
         new_word = {1'b1, ent_aged, ent_page};
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      rd_valid_in = issue;
      rd_idx_in   = addr_ff[IDX_W-1:0];
      ram_we      = 1'b0;
      ram_waddr   = rd_idx_ff;
      ram_wdata   = new_word;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff[IDX_W-1:0];
            ram_wdata = '0;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               addr_in  = '0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            if (pass_done) begin
               state_in = ST_UPDATE;
               addr_in  = '0;
            end
         end
         ST_UPDATE: begin
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            ram_we = rd_valid_ff;
            if (pass_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // item capture, config and fault counter
   assign page_in    = accept ? req_page_number : page_ff;
   assign n_in       = accept ? n_clamp[CNT_W-1:0] : n_ff;
   assign active_in  = (csr_valid && csr_ready) ? csr_active_frames : active_ff;
   assign count_next = (fault && count_ff != '1) ? count_ff + COUNT_W'(1) : count_ff;
   assign count_in   = rsp_load ? count_next : count_ff;
   assign used_wide  = {{USED_W{1'b0}}, tgt_idx};

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         active_ff    <= lrupr_pkg::ACTIVE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_valid_ff  <= rd_valid_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      page_ff   <= page_in;
      n_ff      <= n_in;
      if (rsp_load) begin
         rsp_fault_ff <= fault;
         rsp_used_ff  <= used_wide[USED_W-1:0];
         rsp_count_ff <= count_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_page_fault  = rsp_fault_ff;
   assign rsp_frame_used  = rsp_used_ff;
   assign rsp_fault_count = rsp_count_ff;

   // scan control
   assign scan_ctrl.start  = accept;
   assign scan_ctrl.sample = rd_valid_ff && (state_ff == ST_SCAN);

   lrupr_frame_ram #(
      .DEPTH  (MAX_FRAMES),
      .ADDR_W (IDX_W),
      .DATA_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lrupr_scan #(
      .IDX_W  (IDX_W),
      .RANK_W (RANK_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .idx         (rd_idx_ff),
      .entry_valid (ent_valid),
      .entry_rank  (ent_rank),
      .entry_page  (ent_page),
      .page        (page_ff),
      .flags       (scan_flags),
      .hit_idx     (hit_idx),
      .hit_rank    (hit_rank),
      .empty_idx   (empty_idx),
      .victim_idx  (victim_idx),
      .victim_rank (victim_rank)
   );

   // checks
   `ASSERT_IMPLY(a_no_write_in_scan, clock, reset, state_ff == ST_SCAN, !ram_we,
      "frame ram written during the search pass")
   `ASSERT_IMPLY(a_write_in_range, clock, reset, ram_we && state_ff == ST_UPDATE,
      CNT_W'(ram_waddr) < n_ff, "update pass wrote a frame beyond the active count")
   `ASSERT_IMPLY(a_target_in_range, clock, reset, state_ff == ST_DONE,
      CNT_W'(tgt_idx) < n_ff, "chosen frame beyond the active count")
   `ASSERT_NEXT(a_hit_keeps_count, clock, reset, rsp_load && !fault,
      count_ff == $past(count_ff), "fault count moved on a hit")

endmodule

FILE: design/lrupr_frame_ram.sv
// frame state memory: one write port, one read port, registered read data
// depends on lrupr_pkg for the default depth; word layout is set by the top level
module lrupr_frame_ram #(
   parameter int DEPTH  = lrupr_pkg::DEF_MAX_FRAMES,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 38
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] frame_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= frame_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lrupr_scan.sv
// search accumulator: first hit, first empty frame and oldest valid frame
// depends on lrupr_pkg for the control and flag structs and the page width
module lrupr_scan #(
   parameter int IDX_W  = 6,
   parameter int RANK_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lrupr_pkg::scan_ctrl_type      ctrl,
   input  logic [IDX_W-1:0]              idx,
   input  logic                          entry_valid,
   input  logic [RANK_W-1:0]             entry_rank,
   input  logic [lrupr_pkg::PAGE_W-1:0]  entry_page,
   input  logic [lrupr_pkg::PAGE_W-1:0]  page,
   output lrupr_pkg::scan_flags_type     flags,
   output logic [IDX_W-1:0]              hit_idx,
   output logic [RANK_W-1:0]             hit_rank,
   output logic [IDX_W-1:0]              empty_idx,
   output logic [IDX_W-1:0]              victim_idx,
   output logic [RANK_W-1:0]             victim_rank
);

   logic              hit_ff, hit_in;
   logic              empty_ff, empty_in;
   logic              any_ff, any_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0] hit_rank_ff, hit_rank_in;
   logic [IDX_W-1:0]  empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]  vict_idx_ff, vict_idx_in;
   logic [RANK_W-1:0] vict_rank_ff, vict_rank_in;

   // fold one frame into the running search
   always_comb begin
      hit_in       = hit_ff;
      empty_in     = empty_ff;
      any_in       = any_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      empty_idx_in = empty_idx_ff;
      vict_idx_in  = vict_idx_ff;
      vict_rank_in = vict_rank_ff;
      if (ctrl.start) begin
         hit_in   = 1'b0;
         empty_in = 1'b0;
         any_in   = 1'b0;
      end else if (ctrl.sample) begin
         if (entry_valid) begin
            if (!hit_ff && entry_page == page) begin
               hit_in      = 1'b1;
               hit_idx_in  = idx;
               hit_rank_in = entry_rank;
            end
            // strict compare keeps the lowest index on a tie
            if (!any_ff || entry_rank > vict_rank_ff) begin
               any_in       = 1'b1;
               vict_idx_in  = idx;
               vict_rank_in = entry_rank;
            end
         end else if (!empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = idx;
         end
      end
   end

   // search flags
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         empty_ff <= empty_in;
         any_ff   <= any_in;
      end
   end

   // search payload
   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      empty_idx_ff <= empty_idx_in;
      vict_idx_ff  <= vict_idx_in;
      vict_rank_ff <= vict_rank_in;
   end

   assign flags.hit        = hit_ff;
   assign flags.have_empty = empty_ff;
   assign hit_idx          = hit_idx_ff;
   assign hit_rank         = hit_rank_ff;
   assign empty_idx        = empty_idx_ff;
   assign victim_idx       = vict_idx_ff;
   assign victim_rank      = vict_rank_ff;

endmodule

FILE: dv/lru_page_replacement_checker.sv
`timescale 1ns / 100ps
// checker for the lru page replacement unit: tracks frames, ranks and fault count
// depends on lrupr_pkg; watches the request, result and csr channels from outside
module lru_page_replacement_checker #(
   parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [lrupr_pkg::PAGE_W-1:0]    req_page_number,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_page_fault,
   input  logic [lrupr_pkg::USED_W-1:0]    rsp_frame_used,
   input  logic [lrupr_pkg::COUNT_W-1:0]   rsp_fault_count,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [lrupr_pkg::ACTIVE_W-1:0]  csr_active_frames,
   output int                              failures,
   output int                              pending_results
);
   import lrupr_pkg::*;

   typedef struct packed {
      logic                 page_fault;
      logic [USED_W-1:0]    frame_used;
      logic [COUNT_W-1:0]   fault_count;
   } outcome_type;

   // shadow copy of the frame table
   logic [PAGE_W-1:0]   slot_page [MAX_FRAMES];
   bit                  slot_live [MAX_FRAMES];
   int unsigned         slot_age [MAX_FRAMES];
   logic [COUNT_W-1:0]  miss_total;
   logic [ACTIVE_W-1:0] frame_limit;
   outcome_type         expected_outcomes [$];

   initial failures = 0;
   initial pending_results = 0;

   // frame t becomes newest, valid frames younger than it age by one
   function automatic void make_newest(input int t, input int n);
      int unsigned r;
      r = slot_age[t];
      for (int k = 0; k < n; k++) begin
         if (k != t && slot_live[k] && slot_age[k] < r && slot_age[k] < MAX_FRAMES - 1)
            slot_age[k]++;
      end
      slot_age[t] = 0;
   endfunction

   // one page reference: search, then fill, replace or touch
   function automatic outcome_type lru_lookup(input logic [PAGE_W-1:0] page);
      int          n;
      int          used;
      int          spare;
      int          oldest;
      int unsigned oldest_age;
      bit          found;
      bit          got_spare;
      bit          got_oldest;
      outcome_type o;
      // zero acts as one, oversize acts as the built count
      n = (frame_limit == 0) ? 1 : (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
      used = 0;
      spare = 0;
      oldest = 0;
      oldest_age = 0;
      found = 0;
      got_spare = 0;
      got_oldest = 0;
      for (int k = 0; k < n; k++) begin
         if (slot_live[k]) begin
            if (!found && slot_page[k] == page) begin
               found = 1;
               used = k;
            end
            if (!got_oldest || slot_age[k] > oldest_age) begin
               got_oldest = 1;
               oldest_age = slot_age[k];
               oldest = k;
            end
         end else if (!got_spare) begin
            got_spare = 1;
            spare = k;
         end
      end
      if (found) begin
         make_newest(used, n);
      end else begin
         if (got_spare) begin
            // fill: every valid frame ages
            used = spare;
            for (int k = 0; k < n; k++) begin
               if (slot_live[k] && slot_age[k] < MAX_FRAMES - 1)
                  slot_age[k]++;
            end
            slot_live[used] = 1;
            slot_page[used] = page;
            slot_age[used] = 0;
         end else begin
            // replace the oldest, treated like a hit on it
            used = oldest;
            slot_page[used] = page;
            make_newest(used, n);
         end
         if (miss_total != '1)
            miss_total++;
      end
      o.page_fault  = !found;
      o.frame_used  = used[USED_W-1:0];
      o.fault_count = miss_total;
      return o;
   endfunction

   // track handshakes and compare results in order
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int k = 0; k < MAX_FRAMES; k++) begin
            slot_page[k] = '0;
            slot_live[k] = 0;
            slot_age[k] = 0;
         end
         miss_total = '0;
         frame_limit = ACTIVE_RESET;
         expected_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("result with no reference pending: fault %0d frame %0d count %0d",
                      rsp_page_fault, rsp_frame_used, rsp_fault_count);
               failures++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_page_fault !== want.page_fault) begin
                  $error("page_fault mismatch: expected %0d, actual %0d",
                         want.page_fault, rsp_page_fault);
                  failures++;
               end
               if (rsp_frame_used !== want.frame_used) begin
                  $error("frame_used mismatch: expected %0d, actual %0d",
                         want.frame_used, rsp_frame_used);
                  failures++;
               end
               if (rsp_fault_count !== want.fault_count) begin
                  $error("fault_count mismatch: expected %0d, actual %0d",
                         want.fault_count, rsp_fault_count);
                  failures++;
               end
            end
         end
         if (csr_valid && csr_ready)
            frame_limit = csr_active_frames;
         if (req_valid && req_ready)
            expected_outcomes.insert(expected_outcomes.size(), lru_lookup(req_page_number));
      end
      pending_results <= expected_outcomes.size();
   end

endmodule

FILE: dv/lru_page_replacement_unit_test.sv
`timescale 1ns / 100ps
// top of the lru page replacement unit testbench: clock, reset, stimulus and verdict
// depends on lrupr_pkg, the unit and lru_page_replacement_checker
module lru_page_replacement_unit_test;
   import lrupr_pkg::*;

   localparam int MAX_FRAMES  = DEF_MAX_FRAMES;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [PAGE_W-1:0]    req_page_number;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_page_fault;
   logic [USED_W-1:0]    rsp_frame_used;
   logic [COUNT_W-1:0]   rsp_fault_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [ACTIVE_W-1:0]  csr_active_frames;
   int                   checker_failures;
   int                   pending_results;

   idle_mode_type idle_mode = IDLE_NONE;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int references_sent = 0;
   int settings_written = 0;
   int cycle_count = 0;

   lru_page_replacement_unit #(.MAX_FRAMES(MAX_FRAMES)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_page_fault    (rsp_page_fault),
      .rsp_frame_used    (rsp_frame_used),
      .rsp_fault_count   (rsp_fault_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_active_frames (csr_active_frames)
   );

   lru_page_replacement_checker #(.MAX_FRAMES(MAX_FRAMES)) lru_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_page_fault    (rsp_page_fault),
      .rsp_frame_used    (rsp_frame_used),
      .rsp_fault_count   (rsp_fault_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_active_frames (csr_active_frames),
      .failures          (checker_failures),
      .pending_results   (pending_results)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("lru_page_replacement_unit verification failed");
      $finish;
   end

   // random idle decision for either side under the current mode
   function automatic bit idles_now(input bit sender_side);
      int unsigned roll;
      roll = $urandom_range(99);
      case (idle_mode)
         IDLE_SENDER:   return sender_side && roll < 51;
         IDLE_RECEIVER: return !sender_side && roll < 51;
         IDLE_BOTH:     return roll < 16;
         default:       return 1'b0;
      endcase
   endfunction

   // result side: random stalls plus the occasional long hold-off
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idles_now(1'b0);
      end
   end

   // offer one page reference, with random gaps ahead of it
   task automatic offer_page(input logic [PAGE_W-1:0] page);
      while (idles_now(1'b1)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      references_sent++;
   endtask

   // stop sending until every result is back and the unit takes items again
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0 || !req_ready);
      @(negedge clock);
   endtask

   task automatic write_frame_count(input logic [ACTIVE_W-1:0] count);
      wait_idle();
      csr_valid <= 1'b1;
      csr_active_frames <= count;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   // stimulus and verdict
   initial begin
      int unsigned        frame_settings [14];
      logic [PAGE_W-1:0]  page_pool [$];
      logic [PAGE_W-1:0]  fresh [$];
      logic [PAGE_W-1:0]  page;
      logic [31:0]        draw;
      int                 eff;
      int                 items;
      int                 pool_size;
      int                 random_index;
      int unsigned        roll;
      int                 leftover;

      frame_settings = '{3, 1, 8, 64, 2, 16, 0, 6, 127, 5, 33, 4, 11, 2};
      reset = 1'b1;
      req_valid = 1'b0;
      req_page_number = '0;
      csr_valid = 1'b0;
      csr_active_frames = ACTIVE_RESET;
      random_index = 0;
      leftover = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset frame count of four: fill, hit, field extremes, replacement
      offer_page('0);
      offer_page(PAGE_MAX);
      offer_page('0);
      offer_page(PAGE_W'(1));
      offer_page(PAGE_W'(2));
      offer_page(PAGE_MAX);
      offer_page(PAGE_W'(3));
      offer_page(PAGE_W'(1));
      offer_page('0);

      // zero frame count behaves as one frame
      write_frame_count(ACTIVE_W'(0));
      offer_page(PAGE_W'(5));
      offer_page(PAGE_W'(5));
      offer_page(PAGE_W'(6));

      // oversize count behaves as the full set
      write_frame_count(ACTIVE_W'(127));
      offer_page(31'h2AAAAAAA);
      offer_page(31'h55555555);

      // shrink and regrow: stale frames come back, duplicate page hits lowest index
      write_frame_count(ACTIVE_W'(4));
      offer_page(PAGE_W'(100));
      offer_page(PAGE_W'(101));
      offer_page(PAGE_W'(102));
      offer_page(PAGE_W'(103));
      write_frame_count(ACTIVE_W'(2));
      offer_page(PAGE_W'(103));
      offer_page(PAGE_W'(102));
      write_frame_count(ACTIVE_W'(4));
      offer_page(PAGE_W'(103));
      offer_page(PAGE_W'(102));

      // random phases, one frame count each, drawing mostly from a working set
      for (int phase = 0; phase < 14; phase++) begin
         write_frame_count(ACTIVE_W'(frame_settings[phase]));
         eff = (frame_settings[phase] == 0) ? 1 :
               (frame_settings[phase] > MAX_FRAMES) ? MAX_FRAMES : int'(frame_settings[phase]);
         items = (eff > 16) ? 50 : 70;
         // working set a little larger than the frame count, half kept from before
         pool_size = eff + $urandom_range(eff / 2 + 2, 1);
         fresh.delete();
         for (int j = 0; j < pool_size; j++) begin
            draw = $urandom;
            if (j < page_pool.size() && $urandom_range(1))
               fresh.insert(fresh.size(), page_pool[j]);
            else
               fresh.insert(fresh.size(), draw[PAGE_W-1:0]);
         end
         page_pool = fresh;
         for (int i = 0; i < items; i++) begin
            idle_mode <= idle_mode_type'((random_index / 17) % 4);
            // long result hold-off while items keep coming
            if (phase == 1 && i == 30)
               hold_requests <= hold_requests + 1;
            // sender waits for the unit to drain
            if ((phase == 4 || phase == 10) && i == 35)
               wait_idle();
            roll = $urandom_range(99);
            draw = $urandom;
            if (roll < 84)
               page = page_pool[$urandom_range(page_pool.size() - 1)];
            else if (roll < 95)
               page = draw[PAGE_W-1:0];
            else
               page = $urandom_range(1) ? PAGE_MAX : '0;
            offer_page(page);
            random_index++;
         end
      end

      // drain, then let the unit settle
      idle_mode <= IDLE_NONE;
      wait_idle();
      repeat (2 * MAX_FRAMES + 8) @(posedge clock);
      if (pending_results != 0) begin
         $error("%0d expected results never arrived", pending_results);
         leftover = 1;
      end

      $display("covered %0d page references over %0d frame count writes,",
               references_sent, settings_written);
      $display("with sender gaps, result stalls, a long hold-off and drain pauses");
      if (checker_failures == 0 && leftover == 0)
         $display("lru_page_replacement_unit verification clean");
      else
         $display("lru_page_replacement_unit verification failed");
      $finish;
   end

endmodule
